FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define BPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define BPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants of the barometric compensation datapath.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_C   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_D   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OSS = 3'd4;

  // divider geometry: temperature numerator is mc * 2048, pressure divisor is b4
  localparam int NUM1_W = 27;
  localparam int DEN1_W = 32;
  localparam int NUM2_W = 32;
  localparam int DEN2_W = 17;

  localparam logic signed [31:0] B5_OFFSET   = 32'sd4000;
  localparam logic signed [31:0] X3_OFFSET   = 32'sd32768;
  localparam logic [15:0]        P_SCALE     = 16'd50000;
  localparam logic signed [15:0] PC_SQ_GAIN  = 16'sd3038;
  localparam logic signed [15:0] PC_LIN_GAIN = -16'sd7357;
  localparam logic signed [31:0] PC_OFFSET   = 32'sd3791;

  typedef struct packed {
    logic signed [31:0] x1;
    logic [23:0]        up;
    logic               neg;
    logic               fault;
  } div1_side_t;

  typedef struct packed {
    logic signed [15:0] temp;
    logic               hi;
    logic               fault;
  } div2_side_t;

endpackage

FILE: rtl/bpc_if.sv
// ----------------------------------------------------------------------------
// bpc_if
// Valid/ready channels for raw readings and compensated results.
// ----------------------------------------------------------------------------
interface bpc_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [23:0] raw_pressure_bytes;
  modport source (output valid, output raw_temperature, output raw_pressure_bytes,
                  input ready);
  modport sink (input valid, input raw_temperature, input raw_pressure_bytes,
                output ready);
endinterface

interface bpc_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_tenths;
  logic signed [31:0] pressure_pa;
  logic               divide_fault;
  modport source (output valid, output temperature_tenths, output pressure_pa,
                  output divide_fault, input ready);
  modport sink (input valid, input temperature_tenths, input pressure_pa,
                input divide_fault, output ready);
endinterface

FILE: rtl/bpc_div.sv
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bpc_div #(
  parameter int NW = bpc_pkg::NUM2_W,
  parameter int DW = bpc_pkg::DEN2_W,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] side_out
);

  logic [DW-1:0] rem  [NW];
  logic [NW-1:0] nsh  [NW];
  logic [NW-1:0] qacc [NW];
  logic [DW-1:0] dsr  [NW];
  logic [SW-1:0] sd   [NW];
  logic          vld  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NW-1:0] nsh_in;
    logic [NW-1:0] qacc_in;
    logic [DW-1:0] dsr_in;
    logic [SW-1:0] sd_in;
    logic          vld_in;
    logic [DW:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign nsh_in  = num;
      assign qacc_in = '0;
      assign dsr_in  = den;
      assign sd_in   = side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign rem_in  = rem[k-1];
      assign nsh_in  = nsh[k-1];
      assign qacc_in = qacc[k-1];
      assign dsr_in  = dsr[k-1];
      assign sd_in   = sd[k-1];
      assign vld_in  = vld[k-1];
    end

    assign trial = {rem_in, nsh_in[NW-1]};
    assign take  = (trial >= {1'b0, dsr_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= take ? DW'(trial - {1'b0, dsr_in}) : trial[DW-1:0];
        qacc[k] <= {qacc_in[NW-2:0], take};
        nsh[k]  <= {nsh_in[NW-2:0], 1'b0};
        dsr[k]  <= dsr_in;
        sd[k]   <= sd_in;
      end
    end
  end

  assign out_valid = vld[NW-1];
  assign quo       = qacc[NW-1];
  assign side_out  = sd[NW-1];

endmodule

FILE: rtl/baro_pressure_temp_compensation.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Integer temperature and pressure compensation for a barometric sensor.
//
// Takes one raw temperature / raw pressure pair per transaction and returns
// temperature in 0.1 degree and pressure in pascals. The datapath is a fixed
// pipeline and accepts a new pair every cycle unless the output stalls; the
// pipeline length is set by the two bit-serial divider
// pipelines (27 stages for the temperature division, 32 for the pressure
// division) plus nine arithmetic stages. A stall at the output freezes the whole
// pipeline. Calibration words and oversampling are to be written through the
// cfg port only while the pipeline is empty; the block does not enforce this.
// A zero divisor gives zero results with divide_fault set.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bpc_pkg::CFG_W-1:0]           cfg_wdata,
  bpc_sample_if.sink                          sample,
  bpc_result_if.source                        result
);

  localparam int D1SW = $bits(bpc_pkg::div1_side_t);
  localparam int D2SW = $bits(bpc_pkg::div2_side_t);

  // configuration
  logic [47:0] cfg_a;
  logic [47:0] cfg_b;
  logic [31:0] cfg_c;
  logic [31:0] cfg_d;
  logic [1:0]  cfg_oss;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_a   <= '0;
      cfg_b   <= '0;
      cfg_c   <= '0;
      cfg_d   <= '0;
      cfg_oss <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bpc_pkg::CFG_IDX_A:   cfg_a   <= cfg_wdata[47:0];
        bpc_pkg::CFG_IDX_B:   cfg_b   <= cfg_wdata[47:0];
        bpc_pkg::CFG_IDX_C:   cfg_c   <= cfg_wdata[31:0];
        bpc_pkg::CFG_IDX_D:   cfg_d   <= cfg_wdata[31:0];
        bpc_pkg::CFG_IDX_OSS: cfg_oss <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;

  assign ac1 = cfg_a[15:0];
  assign ac2 = cfg_a[31:16];
  assign ac3 = cfg_a[47:32];
  assign ac4 = cfg_b[15:0];
  assign ac5 = cfg_b[31:16];
  assign ac6 = cfg_b[47:32];
  assign b1  = cfg_c[15:0];
  assign b2  = cfg_c[31:16];
  assign mc  = cfg_d[15:0];
  assign md  = cfg_d[31:16];

  // whole pipeline moves together
  logic en;
  assign en           = !result.valid || result.ready;
  assign sample.ready = en;

  // ---------------- stage 1: x1, divisor, operand magnitudes
  logic signed [16:0] s1c_diff;
  logic signed [33:0] s1c_prod;
  logic signed [31:0] s1c_x1, s1c_den;
  logic signed [26:0] s1c_n;
  logic [3:0]         s1c_sh;

  always_comb begin
    s1c_diff = $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, ac6});
    s1c_prod = s1c_diff * $signed({1'b0, ac5});
    s1c_x1   = $signed(s1c_prod[31:0]) >>> 15;
    s1c_den  = s1c_x1 + 32'(md);
    s1c_n    = {mc, 11'b0};
    s1c_sh   = 4'd8 - {2'b00, cfg_oss};
  end

  logic                         s1_v;
  logic [bpc_pkg::NUM1_W-1:0]   s1_num;
  logic [bpc_pkg::DEN1_W-1:0]   s1_den;
  bpc_pkg::div1_side_t          s1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_num        <= s1c_n[26] ? 27'(-s1c_n) : 27'(s1c_n);
      s1_den        <= s1c_den[31] ? 32'(-s1c_den) : 32'(s1c_den);
      s1_side.x1    <= s1c_x1;
      s1_side.up    <= sample.raw_pressure_bytes >> s1c_sh;
      s1_side.neg   <= s1c_n[26] ^ s1c_den[31];
      s1_side.fault <= (s1c_den == 32'sd0);
    end
  end

  // ---------------- temperature division
  logic                       d1_v;
  logic [bpc_pkg::NUM1_W-1:0] d1_q;
  logic [D1SW-1:0]            d1_sraw;
  bpc_pkg::div1_side_t        d1_side;

  bpc_div #(.NW(bpc_pkg::NUM1_W), .DW(bpc_pkg::DEN1_W), .SW(D1SW)) u_div_t (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s1_v),
    .num      (s1_num),
    .den      (s1_den),
    .side     (D1SW'(s1_side)),
    .out_valid(d1_v),
    .quo      (d1_q),
    .side_out (d1_sraw)
  );

  assign d1_side = bpc_pkg::div1_side_t'(d1_sraw);

  // ---------------- stage 2: b5, temperature, b6
  logic signed [31:0] s2c_x2, s2c_b5, s2c_tw;
  logic signed [15:0] s2c_t;

  always_comb begin
    s2c_x2 = d1_side.neg ? -$signed({5'b0, d1_q}) : $signed({5'b0, d1_q});
    s2c_b5 = d1_side.x1 + s2c_x2;
    s2c_tw = (s2c_b5 + 32'sd8) >>> 4;
    if (s2c_tw > 32'sd32767) begin
      s2c_t = 16'sh7fff;
    end else if (s2c_tw < -32'sd32768) begin
      s2c_t = -16'sh8000;
    end else begin
      s2c_t = s2c_tw[15:0];
    end
  end

  logic               s2_v, s2_fault;
  logic signed [31:0] s2_b6;
  logic signed [15:0] s2_t;
  logic [23:0]        s2_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_b6    <= s2c_b5 - bpc_pkg::B5_OFFSET;
      s2_t     <= s2c_t;
      s2_up    <= d1_side.up;
      s2_fault <= d1_side.fault;
    end
  end

  // ---------------- stage 3: products of b6
  logic signed [63:0] s3c_sq;
  logic signed [47:0] s3c_m2, s3c_m3;

  always_comb begin
    s3c_sq = s2_b6 * s2_b6;
    s3c_m2 = ac2 * s2_b6;
    s3c_m3 = ac3 * s2_b6;
  end

  logic               s3_v, s3_fault;
  logic signed [31:0] s3_sq, s3_x2b, s3_x1c;
  logic signed [15:0] s3_t;
  logic [23:0]        s3_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sq    <= $signed(s3c_sq[31:0]) >>> 12;
      s3_x2b   <= $signed(s3c_m2[31:0]) >>> 11;
      s3_x1c   <= $signed(s3c_m3[31:0]) >>> 13;
      s3_t     <= s2_t;
      s3_up    <= s2_up;
      s3_fault <= s2_fault;
    end
  end

  // ---------------- stage 4: products of the square term
  logic signed [47:0] s4c_mb2, s4c_mb1;

  always_comb begin
    s4c_mb2 = b2 * s3_sq;
    s4c_mb1 = b1 * s3_sq;
  end

  logic               s4_v, s4_fault;
  logic signed [31:0] s4_x1b, s4_x2c, s4_x2b, s4_x1c;
  logic signed [15:0] s4_t;
  logic [23:0]        s4_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_x1b   <= $signed(s4c_mb2[31:0]) >>> 11;
      s4_x2c   <= $signed(s4c_mb1[31:0]) >>> 16;
      s4_x2b   <= s3_x2b;
      s4_x1c   <= s3_x1c;
      s4_t     <= s3_t;
      s4_up    <= s3_up;
      s4_fault <= s3_fault;
    end
  end

  // ---------------- stage 5: b3 and the b4 operand
  logic signed [31:0] s5c_b3a, s5c_b3b, s5c_x3c;

  always_comb begin
    s5c_b3a = (32'(ac1) <<< 2) + s4_x1b + s4_x2b;
    s5c_b3b = s5c_b3a <<< cfg_oss;
    s5c_x3c = (s4_x1c + s4_x2c + 32'sd2) >>> 2;
  end

  logic               s5_v, s5_fault;
  logic signed [31:0] s5_b3, s5_v4;
  logic signed [15:0] s5_t;
  logic [23:0]        s5_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_b3    <= (s5c_b3b + 32'sd2) >>> 2;
      s5_v4    <= s5c_x3c + bpc_pkg::X3_OFFSET;
      s5_t     <= s4_t;
      s5_up    <= s4_up;
      s5_fault <= s4_fault;
    end
  end

  // ---------------- stage 6: b4 and b7
  logic [47:0] s6c_b4w, s6c_b7w;
  logic [31:0] s6c_upd;
  logic [15:0] s6c_scale;

  always_comb begin
    s6c_b4w   = {32'b0, ac4} * {16'b0, s5_v4};
    s6c_upd   = {8'b0, s5_up} - s5_b3;
    s6c_scale = bpc_pkg::P_SCALE >> cfg_oss;
    s6c_b7w   = {16'b0, s6c_upd} * {32'b0, s6c_scale};
  end

  logic                       s6_v, s6_fault;
  logic [bpc_pkg::DEN2_W-1:0] s6_b4;
  logic [31:0]                s6_b7;
  logic signed [15:0]         s6_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_b4    <= s6c_b4w[31:15];
      s6_b7    <= s6c_b7w[31:0];
      s6_t     <= s5_t;
      s6_fault <= s5_fault;
    end
  end

  // ---------------- pressure division
  bpc_pkg::div2_side_t        d2_in_side, d2_side;
  logic [bpc_pkg::NUM2_W-1:0] d2_num;
  logic                       d2_v;
  logic [bpc_pkg::NUM2_W-1:0] d2_q;
  logic [D2SW-1:0]            d2_sraw;

  // large b7 divides first and doubles after, small b7 doubles first
  always_comb begin
    d2_in_side.temp  = s6_t;
    d2_in_side.hi    = s6_b7[31];
    d2_in_side.fault = s6_fault || (s6_b4 == '0);
    d2_num           = s6_b7[31] ? s6_b7 : {s6_b7[30:0], 1'b0};
  end

  bpc_div #(.NW(bpc_pkg::NUM2_W), .DW(bpc_pkg::DEN2_W), .SW(D2SW)) u_div_p (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s6_v),
    .num      (d2_num),
    .den      (s6_b4),
    .side     (D2SW'(d2_in_side)),
    .out_valid(d2_v),
    .quo      (d2_q),
    .side_out (d2_sraw)
  );

  assign d2_side = bpc_pkg::div2_side_t'(d2_sraw);

  // ---------------- stage 8: quadratic correction products
  logic signed [31:0] s8c_p;
  logic signed [23:0] s8c_x1;
  logic signed [47:0] s8c_sq, s8c_lin;

  always_comb begin
    s8c_p   = d2_side.hi ? {d2_q[30:0], 1'b0} : d2_q;
    s8c_x1  = s8c_p[31:8];
    s8c_sq  = s8c_x1 * s8c_x1;
    s8c_lin = bpc_pkg::PC_LIN_GAIN * s8c_p;
  end

  logic               s8_v, s8_fault;
  logic signed [31:0] s8_p, s8_x1sq, s8_x2;
  logic signed [15:0] s8_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else if (en) begin
      s8_v <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_p     <= s8c_p;
      s8_x1sq  <= s8c_sq[31:0];
      s8_x2    <= $signed(s8c_lin[31:0]) >>> 16;
      s8_t     <= d2_side.temp;
      s8_fault <= d2_side.fault;
    end
  end

  // ---------------- stage 9
  logic signed [47:0] s9c_m;
  assign s9c_m = bpc_pkg::PC_SQ_GAIN * s8_x1sq;

  logic               s9_v, s9_fault;
  logic signed [31:0] s9_p, s9_y, s9_x2;
  logic signed [15:0] s9_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_v <= 1'b0;
    end else if (en) begin
      s9_v <= s8_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_y     <= $signed(s9c_m[31:0]) >>> 16;
      s9_p     <= s8_p;
      s9_x2    <= s8_x2;
      s9_t     <= s8_t;
      s9_fault <= s8_fault;
    end
  end

  // ---------------- output register
  logic signed [31:0] s10c_p;
  assign s10c_p = s9_p + ((s9_y + s9_x2 + bpc_pkg::PC_OFFSET) >>> 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= s9_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.temperature_tenths <= s9_fault ? 16'sd0 : s9_t;
      result.pressure_pa        <= s9_fault ? 32'sd0 : s10c_p;
      result.divide_fault       <= s9_fault;
    end
  end

endmodule

FILE: rtl/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks of the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_temp,
  input logic signed [31:0] out_press,
  input logic               out_fault
);

  `BPC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_press), "result dropped or changed under stall")
  `BPC_ASSERT(a_fault_zero, out_valid && out_fault |-> out_temp == 16'sd0 && out_press == 32'sd0, "fault result not zero")
  `BPC_ASSERT(a_ready_flow, in_ready == (!out_valid || out_ready), "input ready does not follow output flow")
  `BPC_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid, "result valid right after reset")

endmodule

bind baro_pressure_temp_compensation bpc_checker u_bpc_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (sample.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .out_temp (result.temperature_tenths),
  .out_press(result.pressure_pa),
  .out_fault(result.divide_fault)
);

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the barometric compensation pipeline. Raw readings
// are sent in random bursts under several calibration sets. Each accepted
// pair is compensated by an in-bench integer model, and every result is
// compared in order with the oldest predicted reading.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_IDLE   = 5000;
  localparam int DRAIN_WAIT = 100;

  typedef struct {
    logic [15:0] ut;
    logic [23:0] praw;
  } reading_t;

  typedef struct {
    logic signed [15:0] temp;
    logic signed [31:0] press;
    logic               fault;
  } compensated_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bpc_pkg::CFG_W-1:0]     cfg_wdata = '0;

  bpc_sample_if sample ();
  bpc_result_if result ();

  baro_pressure_temp_compensation dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .sample    (sample.sink),
    .result    (result.source)
  );

  always #10 clk = ~clk;

  // calibration shadow
  logic [47:0] cal_a = '0, cal_b = '0;
  logic [31:0] cal_c = '0, cal_d = '0;
  logic [1:0]  cal_oss = '0;

  reading_t     readings_to_send[$];
  compensated_t predicted_readings[$];

  int mismatches = 0;
  int sent_count = 0;
  int checked_count = 0;
  int fault_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_phase = 0;

  function automatic longint w32(longint v);
    int t;
    t = int'(v);
    return longint'(t);
  endfunction

  function automatic longint asr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic compensated_t compensate(logic [15:0] ut_raw, logic [23:0] praw);
    compensated_t r;
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    longint ut, up, x1, x2, x3, den, b5, b6, b3, sq, t, p;
    longint unsigned b4, b7, pu, mask;
    int oss;
    mask = 64'hFFFF_FFFF;
    ac1 = $signed(cal_a[15:0]);  ac2 = $signed(cal_a[31:16]); ac3 = $signed(cal_a[47:32]);
    ac4 = cal_b[15:0];           ac5 = cal_b[31:16];          ac6 = cal_b[47:32];
    b1  = $signed(cal_c[15:0]);  b2  = $signed(cal_c[31:16]);
    mc  = $signed(cal_d[15:0]);  md  = $signed(cal_d[31:16]);
    oss = cal_oss;
    ut  = ut_raw;
    up  = praw >> (8 - oss);
    r.temp = '0; r.press = '0; r.fault = 1'b1;

    x1  = asr(w32((ut - ac6) * ac5), 15);
    den = w32(x1 + md);
    if (den == 0) return r;
    x2 = w32((mc * 2048) / den);
    b5 = w32(x1 + x2);
    t  = asr(w32(b5 + 8), 4);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;

    b6 = w32(b5 - longint'(bpc_pkg::B5_OFFSET));
    sq = asr(w32(b6 * b6), 12);
    x1 = asr(w32(b2 * sq), 11);
    x2 = asr(w32(ac2 * b6), 11);
    x3 = w32(x1 + x2);
    b3 = w32(ac1 * 4 + x3);
    b3 = w32(b3 * (longint'(1) << oss));
    b3 = asr(w32(b3 + 2), 2);

    x1 = asr(w32(ac3 * b6), 13);
    x2 = asr(w32(b1 * sq), 16);
    x3 = asr(w32(x1 + x2 + 2), 2);
    b4 = ((longint'(ac4) * (w32(x3 + longint'(bpc_pkg::X3_OFFSET)) & mask)) & mask) >> 15;
    if (b4 == 0) return r;

    b7 = ((w32(up - b3) & mask) * (longint'(bpc_pkg::P_SCALE) >> oss)) & mask;
    // large products are divided first to keep them inside 32 bits
    if (b7 < 64'h8000_0000) pu = (b7 * 2) / b4;
    else pu = ((b7 / b4) * 2) & mask;
    p = w32(pu);

    x1 = asr(p, 8);
    x1 = w32(x1 * x1);
    x1 = asr(w32(x1 * longint'(bpc_pkg::PC_SQ_GAIN)), 16);
    x2 = asr(w32(longint'(bpc_pkg::PC_LIN_GAIN) * p), 16);
    p  = w32(p + asr(w32(x1 + x2 + longint'(bpc_pkg::PC_OFFSET)), 4));

    r.temp = t[15:0]; r.press = p[31:0]; r.fault = 1'b0;
    return r;
  endfunction

  // driver: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      sample.valid <= 1'b0;
      sample.raw_temperature <= '0;
      sample.raw_pressure_bytes <= '0;
    end else begin
      if (sample.valid && sample.ready) begin
        predicted_readings.push_back(compensate(sample.raw_temperature,
                                                sample.raw_pressure_bytes));
        sent_count++;
      end
      if (!sample.valid || sample.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          sample.valid <= 1'b0;
        end else if (readings_to_send.size() > 0) begin
          reading_t it;
          it = readings_to_send.pop_front();
          sample.valid <= 1'b1;
          sample.raw_temperature <= it.ut;
          sample.raw_pressure_bytes <= it.praw;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(40, 0);
            gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
          end
        end else begin
          sample.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        compensated_t want;
        checked_count++;
        if (predicted_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction: temp %0d press %0d fault %0b",
                     result.temperature_tenths, result.pressure_pa, result.divide_fault);
        end else begin
          want = predicted_readings.pop_front();
          if (want.fault) fault_count++;
          if (result.temperature_tenths !== want.temp || result.pressure_pa !== want.press
              || result.divide_fault !== want.fault) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp temp %0d press %0d fault %0b, got %0d %0d %0b",
                       want.temp, want.press, want.fault, result.temperature_tenths,
                       result.pressure_pa, result.divide_fault);
          end
        end
      end
      if (!hold_done && checked_count >= 400) begin
        // one long hold-off so the pipeline fills and backs up the input
        hold_done = 1'b1;
        hold_left = 250;
      end
      stall_phase = (stall_phase + 1) % 64;
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else if (stall_phase < 24) begin
        result.ready <= 1'b1;
      end else begin
        result.ready <= ($urandom_range(3, 0) != 0);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((sample.valid && sample.ready) || (result.valid && result.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= MAX_IDLE) begin
      $display("timeout, no transaction for %0d cycles", MAX_IDLE);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_cal(logic [bpc_pkg::CFG_IDX_W-1:0] idx,
                           logic [bpc_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      bpc_pkg::CFG_IDX_A:   cal_a = value[47:0];
      bpc_pkg::CFG_IDX_B:   cal_b = value[47:0];
      bpc_pkg::CFG_IDX_C:   cal_c = value[31:0];
      bpc_pkg::CFG_IDX_D:   cal_d = value[31:0];
      bpc_pkg::CFG_IDX_OSS: cal_oss = value[1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_cal(logic [47:0] a, logic [47:0] b, logic [31:0] c, logic [31:0] d,
                          logic [1:0] oss);
    write_cal(bpc_pkg::CFG_IDX_A, bpc_pkg::CFG_W'(a));
    write_cal(bpc_pkg::CFG_IDX_B, bpc_pkg::CFG_W'(b));
    write_cal(bpc_pkg::CFG_IDX_C, bpc_pkg::CFG_W'(c));
    write_cal(bpc_pkg::CFG_IDX_D, bpc_pkg::CFG_W'(d));
    write_cal(bpc_pkg::CFG_IDX_OSS, bpc_pkg::CFG_W'(oss));
  endtask

  task automatic queue_reading(logic [15:0] ut, logic [23:0] praw);
    reading_t it;
    it.ut = ut;
    it.praw = praw;
    readings_to_send.push_back(it);
  endtask

  task automatic queue_random(int count);
    repeat (count) begin
      if ($urandom_range(9, 0) < 7)
        queue_reading(16'($urandom_range(32000, 22000)),
                      24'($urandom_range(24'hB00000, 24'h400000)));
      else
        queue_reading(16'($urandom), 24'($urandom));
    end
  endtask

  task automatic drain();
    while (readings_to_send.size() > 0 || sample.valid || predicted_readings.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  initial begin
    // typical factory calibration
    logic [47:0] typ_a, typ_b;
    logic [31:0] typ_c, typ_d;
    typ_a = {16'hC7D1, 16'hFFB8, 16'd408};      // ac3 -14383, ac2 -72, ac1 408
    typ_b = {16'd23153, 16'd32757, 16'd32741};
    typ_c = {16'd4, 16'd6190};
    typ_d = {16'd2868, 16'hDDF9};               // md 2868, mc -8711

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset calibration: md is zero so the temperature divisor is zero
    queue_reading(16'd27898, 24'h5D2300);
    queue_reading(16'hFFFF, 24'hFFFFFF);
    drain();

    load_cal(typ_a, typ_b, typ_c, typ_d, 2'd0);
    queue_reading(16'd27898, 24'h5D2300);
    queue_reading(16'd0, 24'h000000);
    queue_reading(16'hFFFF, 24'hFFFFFF);
    queue_reading(16'd0, 24'hFFFFFF);
    queue_reading(16'hFFFF, 24'h000000);
    queue_reading(16'h8000, 24'h800000);
    queue_reading(16'h7FFF, 24'h7FFFFF);
    queue_reading(16'd23153, 24'h000100);
    queue_reading(16'hAAAA, 24'h555555);
    queue_reading(16'h5555, 24'hAAAAAA);
    queue_random(300);
    drain();

    // zero pressure divisor: ac4 is zero
    load_cal(typ_a, {typ_b[47:16], 16'd0}, typ_c, typ_d, 2'd3);
    queue_reading(16'd27898, 24'h5D2300);
    queue_reading(16'hFFFF, 24'hFFFFFF);
    queue_random(20);
    drain();

    // extremes of the calibration words
    load_cal(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_8000, 2'd3);
    queue_random(150);
    drain();
    load_cal(48'h8000_8000_8000, 48'h0001_0001_0001, 32'h7FFF_7FFF, 32'h8000_7FFF, 2'd1);
    queue_random(150);
    drain();

    for (int oss = 1; oss < 4; oss++) begin
      load_cal(typ_a, typ_b, typ_c, typ_d, 2'(oss));
      queue_random(300);
      drain();
    end

    repeat (4) begin
      load_cal(rand48(), rand48(), $urandom, $urandom, 2'($urandom_range(3, 0)));
      queue_random(100);
      drain();
    end

    $display("sent %0d readings, checked %0d results, %0d with divide fault",
             sent_count, checked_count, fault_count);
    $display("calibration sets: reset, typical at all oversampling, extremes, random");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
